// ----- src/icdm_pkg.sv -----
`default_nettype none
package icdm_pkg;

  localparam int TEMP_W  = 24;
  localparam int COORD_W = 32;
  localparam int DEPTH_W = 31;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int DELTA_W = COORD_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic signed [TEMP_W-1:0] ISO_RESET = {1'b0, {(TEMP_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ISO_VALUE   = 3'd0,
    CFG_WIN_X_LO    = 3'd1,
    CFG_WIN_X_HI    = 3'd2,
    CFG_WIN_Y_LO    = 3'd3,
    CFG_WIN_Y_HI    = 3'd4,
    CFG_SURFACE_Z   = 3'd5,
    CFG_MIN_DEPTH   = 3'd6,
    CFG_TRANSIENT   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_ZCAP,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- src/icdm_if.sv -----
`default_nettype none
interface icdm_face_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [icdm_pkg::TEMP_W-1:0]       temp_owner;
  logic signed [icdm_pkg::TEMP_W-1:0]       temp_neighbour;
  logic signed [icdm_pkg::COORD_W-1:0]      owner_x;
  logic signed [icdm_pkg::COORD_W-1:0]      owner_y;
  logic signed [icdm_pkg::COORD_W-1:0]      owner_z;
  logic signed [icdm_pkg::COORD_W-1:0]      neighbour_x;
  logic signed [icdm_pkg::COORD_W-1:0]      neighbour_y;
  logic signed [icdm_pkg::COORD_W-1:0]      neighbour_z;
  logic                                     last_face;

  modport source (
    output valid, temp_owner, temp_neighbour, owner_x, owner_y, owner_z,
           neighbour_x, neighbour_y, neighbour_z, last_face,
    input  ready
  );
  modport sink (
    input  valid, temp_owner, temp_neighbour, owner_x, owner_y, owner_z,
           neighbour_x, neighbour_y, neighbour_z, last_face,
    output ready
  );
endinterface

interface icdm_res_if;
  logic                              valid;
  logic                              ready;
  logic [icdm_pkg::DEPTH_W-1:0]      iso_depth;
  logic [icdm_pkg::DEPTH_W-1:0]      melt_depth;

  modport source (output valid, iso_depth, melt_depth, input ready);
  modport sink   (input  valid, iso_depth, melt_depth, output ready);
endinterface

interface icdm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [icdm_pkg::CFG_IDX_W-1:0]      index;
  logic [icdm_pkg::CFG_DAT_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/icdm_div.sv -----
`default_nettype none
// Restoring radix-2 divider, one quotient bit per cycle. Expects num <= den.
module icdm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [icdm_pkg::TEMP_W-1:0]   num,
  input  wire logic [icdm_pkg::TEMP_W-1:0]   den,
  output logic      [icdm_pkg::QUO_W-1:0]    quo,
  output icdm_pkg::div_stat_t                stat
);

  localparam int W = icdm_pkg::TEMP_W;

  logic [W:0]                      rem_r;
  logic [W-1:0]                    den_r;
  logic [icdm_pkg::QUO_W-1:0]      quo_r;
  logic [icdm_pkg::CNT_W-1:0]      cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [W+1:0]                    diff;
  logic                            ge;
  logic [W:0]                      rem_keep;

  assign diff     = {1'b0, rem_r} - {2'b00, den_r};
  assign ge       = ~diff[W+1];
  assign rem_keep = ge ? diff[W:0] : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= icdm_pkg::CNT_W'(icdm_pkg::QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == icdm_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      // remainder stays below den after the trial subtract, so the shift fits
      rem_r <= {rem_keep[W-1:0], 1'b0};
      quo_r <= {quo_r[icdm_pkg::QUO_W-2:0], ge};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ----- src/icdm_lerp.sv -----
`default_nettype none
// Shared interpolation unit: point = base + floor(delta * frac / 2^16).
// The product is registered; the add follows the register.
module icdm_lerp (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [icdm_pkg::COORD_W-1:0]  base,
  input  wire logic signed [icdm_pkg::DELTA_W-1:0]  delta,
  input  wire logic        [icdm_pkg::QUO_W-1:0]    frac,
  output logic      signed [icdm_pkg::COORD_W-1:0]  point
);

  localparam int PROD_W = icdm_pkg::DELTA_W + icdm_pkg::QUO_W + 1;
  localparam int Q_W    = PROD_W - icdm_pkg::FRAC_W;

  logic signed [PROD_W-1:0]              prod_nxt;
  logic signed [PROD_W-1:0]              prod_r;
  logic signed [icdm_pkg::COORD_W-1:0]   base_r;
  logic signed [Q_W-1:0]                 q;
  logic signed [Q_W-1:0]                 sum;

  assign prod_nxt = PROD_W'(delta) * PROD_W'(signed'({1'b0, frac}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      base_r <= base;
    end
  end

  // drop the fraction bits: an arithmetic shift rounds toward minus infinity
  assign q     = prod_r[PROD_W-1:icdm_pkg::FRAC_W];
  assign sum   = Q_W'(base_r) + q;
  assign point = sum[icdm_pkg::COORD_W-1:0];

endmodule
`default_nettype wire

// ----- src/isotherm_crossing_depth_max.sv -----
`default_nettype none
// Isotherm crossing depth tracker. Each face transaction on in_face carries two
// cell temperatures and the two cell centres. When the isotherm temperature
// lies above the lower and at or below the higher face temperature, the
// crossing point is interpolated linearly (Q1.16 fraction, coordinates rounded
// toward minus infinity). A crossing inside the x/y window (bounds inclusive)
// and at or below surface_z adds its depth below the surface, saturated at
// 2^31-1, to a running maximum. A face with last_face set produces one result
// transaction on out_res (iso_depth, and melt_depth = max(min_depth, iso_depth))
// and clears the maximum; with transient_r low the result is 0 and
// min_depth. A face that crosses the isotherm goes from its acceptance to the
// earliest next acceptance through the accepting idle state, a setup state,
// the restoring divider that forms the fraction (one quotient bit at a time,
// then the hand-over), three passes through the shared multiplier for x, y
// and z, and states to capture z, update and finish. Any other face goes
// from setup straight to finish. The result sits in an output register, so the
// next face is taken while a result waits; a last face holds in its final state
// only while an earlier result is still unclaimed. Configuration writes on
// cfg_wr are ready whenever reset is released and must arrive only while the
// block is idle.
module isotherm_crossing_depth_max (
  input  wire logic   clk,
  input  wire logic   rst_n,
  icdm_face_if.sink   in_face,
  icdm_res_if.source  out_res,
  icdm_cfg_if.sink    cfg_wr
);

  localparam int TW = icdm_pkg::TEMP_W;
  localparam int CW = icdm_pkg::COORD_W;
  localparam int DW = icdm_pkg::DEPTH_W;
  localparam int XW = icdm_pkg::DELTA_W;

  // configuration registers
  logic signed [TW-1:0]  iso_value_r;
  logic signed [CW-1:0]  win_x_lo_r;
  logic signed [CW-1:0]  win_x_hi_r;
  logic signed [CW-1:0]  win_y_lo_r;
  logic signed [CW-1:0]  win_y_hi_r;
  logic signed [CW-1:0]  surface_z_r;
  logic [DW-1:0]         min_depth_r;
  logic                  transient_r;

  // captured face
  logic signed [TW-1:0]  t_own_r;
  logic signed [TW-1:0]  t_nbr_r;
  logic signed [CW-1:0]  own_x_r;
  logic signed [CW-1:0]  own_y_r;
  logic signed [CW-1:0]  own_z_r;
  logic signed [XW-1:0]  dlt_x_r;
  logic signed [XW-1:0]  dlt_y_r;
  logic signed [XW-1:0]  dlt_z_r;
  logic                  last_r;

  icdm_pkg::state_t      state_r;
  icdm_pkg::state_t      state_nxt;
  icdm_pkg::axis_t       axis_r;
  logic                  in_x_r;
  logic                  in_y_r;
  logic signed [CW-1:0]  pz_r;
  logic [DW-1:0]         max_depth_r;
  logic                  out_valid_r;
  logic [DW-1:0]         out_iso_r;
  logic [DW-1:0]         out_melt_r;

  // sequencer outputs
  logic                  in_ready;
  logic                  div_start;
  logic                  lerp_en;

  logic                  in_acc;
  logic                  hit;
  logic signed [TW-1:0]  t_min;
  logic signed [TW-1:0]  t_max;
  logic signed [TW:0]    num_s;
  logic signed [TW:0]    den_s;
  logic signed [TW:0]    num_abs;
  logic signed [TW:0]    den_abs;
  logic                  slot_free;
  logic                  emit;

  logic [icdm_pkg::QUO_W-1:0] frac;
  icdm_pkg::div_stat_t   div_stat;
  logic signed [CW-1:0]  lerp_base;
  logic signed [XW-1:0]  lerp_delta;
  logic signed [CW-1:0]  point;

  logic                  qualify;
  logic signed [CW:0]    dep_wide;
  logic [DW-1:0]         dep_sat;
  logic [DW-1:0]         iso_out;

  assign in_acc = in_face.valid && in_ready;

  // ---------------------------------------------------------------- config
  assign cfg_wr.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_value_r <= icdm_pkg::ISO_RESET;
      win_x_lo_r  <= '0;
      win_x_hi_r  <= '0;
      win_y_lo_r  <= '0;
      win_y_hi_r  <= '0;
      surface_z_r <= '0;
      min_depth_r <= '0;
      transient_r <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (icdm_pkg::cfg_idx_t'(cfg_wr.index))
        icdm_pkg::CFG_ISO_VALUE: iso_value_r <= cfg_wr.data[TW-1:0];
        icdm_pkg::CFG_WIN_X_LO:  win_x_lo_r  <= cfg_wr.data[CW-1:0];
        icdm_pkg::CFG_WIN_X_HI:  win_x_hi_r  <= cfg_wr.data[CW-1:0];
        icdm_pkg::CFG_WIN_Y_LO:  win_y_lo_r  <= cfg_wr.data[CW-1:0];
        icdm_pkg::CFG_WIN_Y_HI:  win_y_hi_r  <= cfg_wr.data[CW-1:0];
        icdm_pkg::CFG_SURFACE_Z: surface_z_r <= cfg_wr.data[CW-1:0];
        icdm_pkg::CFG_MIN_DEPTH: min_depth_r <= cfg_wr.data[DW-1:0];
        icdm_pkg::CFG_TRANSIENT: transient_r <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- face capture
  // Take the deltas right away so each multiplier pass starts from a register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_own_r <= in_face.temp_owner;
      t_nbr_r <= in_face.temp_neighbour;
      own_x_r <= in_face.owner_x;
      own_y_r <= in_face.owner_y;
      own_z_r <= in_face.owner_z;
      dlt_x_r <= XW'(in_face.neighbour_x) - XW'(in_face.owner_x);
      dlt_y_r <= XW'(in_face.neighbour_y) - XW'(in_face.owner_y);
      dlt_z_r <= XW'(in_face.neighbour_z) - XW'(in_face.owner_z);
      last_r  <= in_face.last_face;
    end
  end

  // ------------------------------------------------------------ range test
  // Isotherm strictly above the colder cell and at or below the warmer one.
  // That also rules out equal temperatures, so the divisor is never zero.
  assign t_min   = (t_own_r < t_nbr_r) ? t_own_r : t_nbr_r;
  assign t_max   = (t_own_r < t_nbr_r) ? t_nbr_r : t_own_r;
  assign hit     = transient_r && (t_min < iso_value_r) && (t_max >= iso_value_r);
  assign num_s   = (TW+1)'(iso_value_r) - (TW+1)'(t_own_r);
  assign den_s   = (TW+1)'(t_nbr_r) - (TW+1)'(t_own_r);
  assign num_abs = num_s[TW] ? -num_s : num_s;
  assign den_abs = den_s[TW] ? -den_s : den_s;

  icdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_abs[TW-1:0]),
    .den   (den_abs[TW-1:0]),
    .quo   (frac),
    .stat  (div_stat)
  );

  // --------------------------------------------------- shared interpolator
  always_comb begin
    case (axis_r)
      icdm_pkg::AXIS_X: begin
        lerp_base  = own_x_r;
        lerp_delta = dlt_x_r;
      end
      icdm_pkg::AXIS_Y: begin
        lerp_base  = own_y_r;
        lerp_delta = dlt_y_r;
      end
      icdm_pkg::AXIS_Z: begin
        lerp_base  = own_z_r;
        lerp_delta = dlt_z_r;
      end
      default: begin
        lerp_base  = own_z_r;
        lerp_delta = dlt_z_r;
      end
    endcase
  end

  icdm_lerp u_lerp (
    .clk   (clk),
    .en    (lerp_en),
    .base  (lerp_base),
    .delta (lerp_delta),
    .frac  (frac),
    .point (point)
  );

  // Each pass lands in the following cycle: check x while y is issued, y while z is.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= icdm_pkg::AXIS_X;
    end else if (state_r == icdm_pkg::ST_MUL) begin
      case (axis_r)
        icdm_pkg::AXIS_X: axis_r <= icdm_pkg::AXIS_Y;
        icdm_pkg::AXIS_Y: axis_r <= icdm_pkg::AXIS_Z;
        default:          axis_r <= icdm_pkg::AXIS_X;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == icdm_pkg::ST_MUL && axis_r == icdm_pkg::AXIS_Y) begin
      in_x_r <= (point >= win_x_lo_r) && (point <= win_x_hi_r);
    end
    if (state_r == icdm_pkg::ST_MUL && axis_r == icdm_pkg::AXIS_Z) begin
      in_y_r <= (point >= win_y_lo_r) && (point <= win_y_hi_r);
    end
    if (state_r == icdm_pkg::ST_ZCAP) begin
      pz_r <= point;
    end
  end

  // ------------------------------------------------------------- depth update
  assign qualify  = in_x_r && in_y_r && (pz_r <= surface_z_r);
  assign dep_wide = (CW+1)'(surface_z_r) - (CW+1)'(pz_r);
  // saturate: a qualifying depth is never negative, so only the top bits matter
  assign dep_sat  = (dep_wide[CW:DW] != '0) ? icdm_pkg::DEPTH_MAX : dep_wide[DW-1:0];

  assign slot_free = !out_valid_r || out_res.ready;
  assign emit      = (state_r == icdm_pkg::ST_DONE) && last_r && slot_free;
  assign iso_out   = transient_r ? max_depth_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= '0;
    end else if (emit) begin
      max_depth_r <= '0;
    end else if (state_r == icdm_pkg::ST_UPD && qualify && dep_sat > max_depth_r) begin
      max_depth_r <= dep_sat;
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_iso_r  <= iso_out;
      out_melt_r <= (iso_out > min_depth_r) ? iso_out : min_depth_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.iso_depth  = out_iso_r;
  assign out_res.melt_depth = out_melt_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icdm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icdm_pkg::ST_IDLE:  if (in_face.valid) state_nxt = icdm_pkg::ST_SETUP;
      icdm_pkg::ST_SETUP: state_nxt = hit ? icdm_pkg::ST_DIV : icdm_pkg::ST_DONE;
      icdm_pkg::ST_DIV:   if (div_stat.done) state_nxt = icdm_pkg::ST_MUL;
      icdm_pkg::ST_MUL:   if (axis_r == icdm_pkg::AXIS_Z) state_nxt = icdm_pkg::ST_ZCAP;
      icdm_pkg::ST_ZCAP:  state_nxt = icdm_pkg::ST_UPD;
      icdm_pkg::ST_UPD:   state_nxt = icdm_pkg::ST_DONE;
      icdm_pkg::ST_DONE:  if (!last_r || slot_free) state_nxt = icdm_pkg::ST_IDLE;
      default:            state_nxt = icdm_pkg::ST_IDLE;
    endcase
  end

  // hold ready low while reset is asserted
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    lerp_en   = 1'b0;
    case (state_r)
      icdm_pkg::ST_IDLE:  in_ready  = rst_n;
      icdm_pkg::ST_SETUP: div_start = hit;
      icdm_pkg::ST_MUL:   lerp_en   = 1'b1;
      default: ;
    endcase
  end

  assign in_face.ready = in_ready;

endmodule
`default_nettype wire
